### hdl/sccc_pkg.sv
package sccc_pkg;

    localparam int NUM_PROCS  = 4;
    localparam int SETS       = 256;
    localparam int WAYS       = 8;
    localparam int LINE_BYTES = 64;
    localparam int ADDR_BITS  = 32;

    localparam int PROC_W   = $clog2(NUM_PROCS);
    localparam int SET_W    = $clog2(SETS);
    localparam int WAY_W    = $clog2(WAYS);
    localparam int OFS_W    = $clog2(LINE_BYTES);
    localparam int TAG_W    = ADDR_BITS - OFS_W - SET_W;
    localparam int ROW_W    = PROC_W + SET_W;
    localparam int ROWS     = NUM_PROCS * SETS;
    localparam int STAMP_W  = 32;

    typedef logic [2:0] lstate_t;
    localparam lstate_t ST_I  = 3'd0;
    localparam lstate_t ST_S  = 3'd1;
    localparam lstate_t ST_M  = 3'd2;
    localparam lstate_t ST_E  = 3'd3;
    localparam lstate_t ST_SC = 3'd4;
    localparam lstate_t ST_SM = 3'd5;

    typedef logic [1:0] proto_t;
    localparam proto_t PROTO_MSI    = 2'd0;
    localparam proto_t PROTO_MESI   = 2'd1;
    localparam proto_t PROTO_DRAGON = 2'd2;

    localparam logic CFG_PROTOCOL = 1'b0;
    localparam logic CFG_ACTIVE   = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;   // latch the request and start the row reads
        logic update;    // compute and write back the rows
        logic clear;     // clearing pass write of row clr_row
        logic [ROW_W-1:0] clr_row;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        lstate_t final_state;
        logic bus_read;
        logic bus_read_exclusive;
        logic bus_upgrade;
        logic bus_update;
        logic victim_writeback;
        logic cache_to_cache;
        logic [1:0] interventions;
        logic [1:0] invalidations;
        logic [1:0] flushes;
        logic [1:0] clean_supplies;
    } result_t;

    function automatic logic [1:0] sat3(input logic [PROC_W:0] v);
        return (v > 3) ? 2'd3 : v[1:0];
    endfunction

endpackage

### hdl/sccc_ctrl.sv
module sccc_ctrl
    import sccc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_OUT} st_t;

    st_t             state_reg;
    logic [ROW_W:0]  clr_reg;

    assign s_ready       = (state_reg == S_IDLE) || (state_reg == S_OUT && m_ready);
    assign m_valid       = (state_reg == S_OUT);
    assign cmd.capture   = s_valid && s_ready;
    assign cmd.update    = (state_reg == S_LOOK);
    assign cmd.clear     = (state_reg == S_CLEAR);
    assign cmd.clr_row   = clr_reg[ROW_W-1:0];

    // Sequencer: clearing pass, then lookup and update per transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (ROWS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (s_valid) state_reg <= S_LOOK;
                S_LOOK: state_reg <= S_OUT;
                S_OUT: begin
                    if (m_ready) state_reg <= s_valid ? S_LOOK : S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_after_look: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LOOK |=> m_valid) else $error("result not presented");
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_ready) else $error("accept during clear");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");

endmodule

### hdl/sccc_datapath.sv
module sccc_datapath
    import sccc_pkg::*;
(
    input  logic                aclk,
    input  dp_cmd_t             cmd,
    input  logic [PROC_W-1:0]   req_in,
    input  logic [31:0]         addr_in,
    input  logic                wr_in,
    input  logic                cfg_we,
    input  logic                cfg_idx,
    input  logic [2:0]          cfg_data,
    input  logic                aresetn,
    output result_t             res
);

    typedef logic [WAYS-1:0][TAG_W-1:0]   tag_row_t;
    typedef logic [WAYS-1:0][2:0]         st_row_t;
    typedef logic [WAYS-1:0][STAMP_W-1:0] stamp_row_t;

    // One row per cache per set; every cache's row of the set is read at once.
    tag_row_t   tag_mem   [NUM_PROCS][SETS];
    st_row_t    st_mem    [NUM_PROCS][SETS];
    stamp_row_t stamp_mem [NUM_PROCS][SETS];

    tag_row_t   tag_rd_reg   [NUM_PROCS];
    st_row_t    st_rd_reg    [NUM_PROCS];
    stamp_row_t stamp_rd_reg [NUM_PROCS];

    logic [STAMP_W-1:0] acc_reg [NUM_PROCS];
    logic [1:0]         proto_reg;
    logic [2:0]         active_reg;
    logic [PROC_W-1:0]  req_reg;
    logic [SET_W-1:0]   set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               wr_reg;
    result_t            res_reg;

    logic [SET_W-1:0] set_in;
    assign set_in = addr_in[OFS_W +: SET_W];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proto_reg  <= PROTO_MSI;
            active_reg <= 3'd4;
        end else if (cfg_we) begin
            if (cfg_idx == CFG_PROTOCOL) proto_reg <= cfg_data[1:0];
            else                         active_reg <= cfg_data;
        end
    end

    // Row reads on capture.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= req_in;
            set_reg <= set_in;
            tag_reg <= addr_in[OFS_W+SET_W +: TAG_W];
            wr_reg  <= wr_in;
            for (int p = 0; p < NUM_PROCS; p++) begin
                tag_rd_reg[p]   <= tag_mem[p][set_in];
                st_rd_reg[p]    <= st_mem[p][set_in];
                stamp_rd_reg[p] <= stamp_mem[p][set_in];
            end
        end
    end

    // Lookup, snoop and allocation logic.
    logic [NUM_PROCS-1:0] match;
    logic [WAY_W-1:0]     mway [NUM_PROCS];
    lstate_t              mst  [NUM_PROCS];
    lstate_t              nst  [NUM_PROCS];
    logic [NUM_PROCS-1:0] snp;
    logic [PROC_W:0]      lim;
    logic [PROC_W:0]      c_int, c_inv, c_fl, c_cl, n_hold;
    logic                 r_hit, r_rd, r_rdx, r_upg, r_upd, r_wb, r_c2c;
    lstate_t              r_st, vst;
    logic [WAY_W-1:0]     vway, rway;
    logic                 found_inv;
    logic [STAMP_W-1:0]   mn, now;
    logic                 op_rd, op_x, op_upg, op_upd;

    always_comb begin
        lim = (active_reg > NUM_PROCS) ? (PROC_W+1)'(NUM_PROCS) : active_reg[PROC_W:0];
        for (int p = 0; p < NUM_PROCS; p++) begin
            match[p] = 1'b0;
            mway[p]  = '0;
            for (int w = 0; w < WAYS; w++) begin
                if (!match[p] && st_rd_reg[p][w] != ST_I && tag_rd_reg[p][w] == tag_reg) begin
                    match[p] = 1'b1;
                    mway[p]  = WAY_W'(w);
                end
            end
            mst[p] = st_rd_reg[p][mway[p]];
            snp[p] = match[p] && (p != req_reg) && (p < lim);
        end
        r_hit = match[req_reg];
        now   = acc_reg[req_reg] + 1'b1;
        // Victim choice.
        found_inv = 1'b0;
        vway = '0;
        mn   = stamp_rd_reg[req_reg][0];
        for (int w = 0; w < WAYS; w++) begin
            if (!found_inv && st_rd_reg[req_reg][w] == ST_I) begin
                found_inv = 1'b1;
                vway = WAY_W'(w);
            end
        end
        if (!found_inv) begin
            for (int w = 1; w < WAYS; w++) begin
                if (stamp_rd_reg[req_reg][w] <= mn) begin
                    mn = stamp_rd_reg[req_reg][w];
                    vway = WAY_W'(w);
                end
            end
        end
        rway = r_hit ? mway[req_reg] : vway;
        vst  = st_rd_reg[req_reg][vway];
        r_wb = !r_hit && (vst == ST_M || vst == ST_SM);
        n_hold = '0;
        for (int p = 0; p < NUM_PROCS; p++) n_hold = n_hold + (PROC_W+1)'(snp[p]);

        r_rd = 1'b0; r_rdx = 1'b0; r_upg = 1'b0; r_upd = 1'b0; r_c2c = 1'b0;
        r_st = mst[req_reg];
        op_rd = 1'b0; op_x = 1'b0; op_upg = 1'b0; op_upd = 1'b0;
        if (!r_hit) begin
            case (proto_reg)
                PROTO_MSI: begin
                    r_rdx = wr_reg; r_rd = !wr_reg;
                    r_st = wr_reg ? ST_M : ST_S;
                    op_x = wr_reg; op_rd = !wr_reg;
                end
                PROTO_MESI: begin
                    r_c2c = n_hold != 0;
                    r_rdx = wr_reg; r_rd = !wr_reg;
                    r_st = wr_reg ? ST_M : (r_c2c ? ST_S : ST_E);
                    op_x = wr_reg; op_rd = !wr_reg;
                end
                default: begin
                    r_rd = 1'b1; r_upd = wr_reg; op_rd = 1'b1; op_upd = wr_reg;
                    // Snooping never removes a Dragon copy, so holders stay.
                    if (wr_reg) r_st = (n_hold != 0) ? ST_SM : ST_M;
                    else        r_st = (n_hold != 0) ? ST_SC : ST_E;
                end
            endcase
        end else begin
            case (proto_reg)
                PROTO_MSI: if (r_st == ST_S && wr_reg) begin
                    r_st = ST_M; r_rdx = 1'b1; op_x = 1'b1;
                end
                PROTO_MESI: begin
                    if (r_st == ST_S) begin
                        if (wr_reg) begin r_st = ST_M; r_upg = 1'b1; op_upg = 1'b1; end
                    end else if (r_st != ST_M) begin
                        if (wr_reg) r_st = ST_M;
                    end
                end
                default: begin
                    if (r_st == ST_M) begin
                    end else if (r_st == ST_E) begin
                        if (wr_reg) r_st = ST_M;
                    end else if (wr_reg) begin
                        r_upd = 1'b1; op_upd = 1'b1;
                        if (n_hold == 0) r_st = ST_M;
                        else if (r_st != ST_SM) r_st = ST_SM;
                    end
                end
            endcase
        end

        // Snoop responses of the other caches.
        c_int = '0; c_inv = '0; c_fl = '0; c_cl = '0;
        for (int p = 0; p < NUM_PROCS; p++) begin
            nst[p] = mst[p];
            if (snp[p]) begin
                case (proto_reg)
                    PROTO_MSI: begin
                        if (op_rd) begin
                            if (mst[p] == ST_M) begin
                                nst[p] = ST_S; c_fl = c_fl + 1'b1; c_int = c_int + 1'b1;
                            end
                        end else if (op_x) begin
                            if (mst[p] == ST_M) begin
                                nst[p] = ST_I; c_inv = c_inv + 1'b1; c_fl = c_fl + 1'b1;
                            end else if (mst[p] == ST_S) begin
                                nst[p] = ST_I; c_inv = c_inv + 1'b1;
                            end
                        end
                    end
                    PROTO_MESI: begin
                        if (op_rd) begin
                            if (mst[p] == ST_M) begin
                                nst[p] = ST_S; c_fl = c_fl + 1'b1; c_int = c_int + 1'b1;
                            end else if (mst[p] == ST_E) begin
                                nst[p] = ST_S; c_cl = c_cl + 1'b1; c_int = c_int + 1'b1;
                            end else if (mst[p] == ST_S) begin
                                c_cl = c_cl + 1'b1;
                            end
                        end else if (op_x) begin
                            if (mst[p] == ST_M) begin
                                nst[p] = ST_I; c_fl = c_fl + 1'b1; c_inv = c_inv + 1'b1;
                            end else if (mst[p] == ST_E || mst[p] == ST_S) begin
                                nst[p] = ST_I; c_cl = c_cl + 1'b1; c_inv = c_inv + 1'b1;
                            end
                        end else if (op_upg) begin
                            if (mst[p] == ST_S) begin
                                nst[p] = ST_I; c_inv = c_inv + 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (op_rd) begin
                            if (mst[p] == ST_E) begin
                                nst[p] = ST_SC; c_int = c_int + 1'b1;
                            end else if (mst[p] == ST_M) begin
                                nst[p] = ST_SM; c_fl = c_fl + 1'b1; c_int = c_int + 1'b1;
                            end else if (mst[p] == ST_SM) begin
                                c_fl = c_fl + 1'b1;
                            end
                        end
                        if (op_upd && nst[p] == ST_SM) nst[p] = ST_SC;
                    end
                endcase
            end
        end
    end

    // Row write back, access stamps and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_PROCS; p++) acc_reg[p] <= '0;
        end else if (cmd.update && proto_reg <= PROTO_DRAGON) begin
            acc_reg[req_reg] <= now;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            st_mem[cmd.clr_row[ROW_W-1 -: PROC_W]][cmd.clr_row[SET_W-1:0]]    <= '0;
            stamp_mem[cmd.clr_row[ROW_W-1 -: PROC_W]][cmd.clr_row[SET_W-1:0]] <= '0;
        end else if (cmd.update && proto_reg <= PROTO_DRAGON) begin
            for (int p = 0; p < NUM_PROCS; p++) begin
                st_row_t sr;
                stamp_row_t mr;
                tag_row_t tr;
                sr = st_rd_reg[p];
                mr = stamp_rd_reg[p];
                tr = tag_rd_reg[p];
                if (p == req_reg) begin
                    sr[rway] = r_st;
                    mr[rway] = now;
                    tr[rway] = tag_reg;
                end else if (snp[p]) begin
                    sr[mway[p]] = nst[p];
                end
                st_mem[p][set_reg]    <= sr;
                stamp_mem[p][set_reg] <= mr;
                tag_mem[p][set_reg]   <= tr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            if (proto_reg > PROTO_DRAGON) begin
                res_reg <= '0;
            end else begin
                res_reg.hit                <= r_hit;
                res_reg.final_state        <= r_st;
                res_reg.bus_read           <= r_rd;
                res_reg.bus_read_exclusive <= r_rdx;
                res_reg.bus_upgrade        <= r_upg;
                res_reg.bus_update         <= r_upd;
                res_reg.victim_writeback   <= r_wb;
                res_reg.cache_to_cache     <= r_c2c;
                res_reg.interventions      <= sat3(c_int);
                res_reg.invalidations      <= sat3(c_inv);
                res_reg.flushes            <= sat3(c_fl);
                res_reg.clean_supplies     <= sat3(c_cl);
            end
        end
    end

    assign res = res_reg;

    a_hit_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update && r_hit |-> !r_wb) else $error("writeback on hit");
    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> $onehot0({r_rdx, r_upg, op_rd && !r_upd && r_rd && r_rdx}))
        else $error("conflicting bus operations");
    a_req_not_snooped: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> !snp[req_reg]) else $error("requester snooped itself");

endmodule

### hdl/snoopy_coherence_cache_controller_core.sv
// Channel   | Handshake           | Payload
// ----------+---------------------+------------------------------------------
// input     | s_valid / s_ready   | s_requester, s_address, s_func
// result    | m_valid / m_ready   | m_hit .. m_clean_supplies
// config    | cfg_we              | cfg_index, cfg_data
//
// Each transfer first reads every cache's row of the set, then resolves the
// snoop and writes the rows back; the result is then held.
// A new transfer is taken in the cycle the result is taken.
// After reset a clearing pass over the NUM_PROCS*SETS (1024) rows clears the
// state and stamp rows; no transfer is accepted meanwhile.
// A stalled result blocks further input until it is taken.
module snoopy_coherence_cache_controller_core
    import sccc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_requester,
    input  logic [31:0] s_address,
    input  logic        s_func,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [2:0]  m_final_state,
    output logic        m_bus_read,
    output logic        m_bus_read_exclusive,
    output logic        m_bus_upgrade,
    output logic        m_bus_update,
    output logic        m_victim_writeback,
    output logic        m_cache_to_cache,
    output logic [1:0]  m_interventions,
    output logic [1:0]  m_invalidations,
    output logic [1:0]  m_flushes,
    output logic [1:0]  m_clean_supplies
);

    dp_cmd_t cmd;
    result_t res;

    sccc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    sccc_datapath u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .req_in   (s_requester[PROC_W-1:0]),
        .addr_in  (s_address),
        .wr_in    (s_func),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .aresetn  (aresetn),
        .res      (res)
    );

    assign m_hit                = res.hit;
    assign m_final_state        = res.final_state;
    assign m_bus_read           = res.bus_read;
    assign m_bus_read_exclusive = res.bus_read_exclusive;
    assign m_bus_upgrade        = res.bus_upgrade;
    assign m_bus_update         = res.bus_update;
    assign m_victim_writeback   = res.victim_writeback;
    assign m_cache_to_cache     = res.cache_to_cache;
    assign m_interventions      = res.interventions;
    assign m_invalidations      = res.invalidations;
    assign m_flushes            = res.flushes;
    assign m_clean_supplies     = res.clean_supplies;

endmodule

### bench/snoopy_coherence_cache_controller_core_tb.sv
module snoopy_coherence_cache_controller_core_tb
    import sccc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Bus operations seen by the snooping caches.
    localparam int BUS_RD   = 1;
    localparam int BUS_RDX  = 2;
    localparam int BUS_UPGR = 3;
    localparam int BUS_UPD  = 4;

    // Protocol code with no protocol behind it.
    localparam proto_t PROTO_NONE = 2'd3;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 193;

    // Protocol and active cache count of each random phase.
    localparam proto_t PHASE_PROTO [NUM_PHASES] = '{PROTO_MESI, PROTO_DRAGON, PROTO_MSI,
        PROTO_NONE, PROTO_MESI, PROTO_DRAGON, PROTO_MESI, PROTO_MSI, PROTO_DRAGON,
        PROTO_MESI};
    localparam logic [2:0] PHASE_ACTIVE [NUM_PHASES] = '{3'd4, 3'd4, 3'd7, 3'd4, 3'd2,
        3'd0, 3'd1, 3'd3, 3'd4, 3'd4};

    typedef struct packed {
        logic [1:0]  requester;
        logic [31:0] address;
        logic        func;
    } access_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_PROTOCOL;
    logic [2:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_requester = '0;
    logic [31:0] s_address = '0;
    logic        s_func = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_hit;
    logic [2:0]  m_final_state;
    logic        m_bus_read;
    logic        m_bus_read_exclusive;
    logic        m_bus_upgrade;
    logic        m_bus_update;
    logic        m_victim_writeback;
    logic        m_cache_to_cache;
    logic [1:0]  m_interventions;
    logic [1:0]  m_invalidations;
    logic [1:0]  m_flushes;
    logic [1:0]  m_clean_supplies;

    snoopy_coherence_cache_controller_core DUT (.*);

    always #6 aclk = ~aclk;

    // Shadow copy of the cache arrays and the configuration.
    logic [TAG_W-1:0]   shadow_tag   [NUM_PROCS][SETS][WAYS];
    lstate_t            shadow_state [NUM_PROCS][SETS][WAYS];
    logic [STAMP_W-1:0] shadow_stamp [NUM_PROCS][SETS][WAYS];
    logic [STAMP_W-1:0] proc_clock   [NUM_PROCS];
    proto_t             cur_proto;
    logic [2:0]         cur_active;

    access_t pending_accesses[$];
    result_t expected_results[$];
    int      src_idle = 0;
    int      snk_idle = 0;
    int      mismatches = 0;
    int      cycles = 0;
    bit      input_taken = 0;

    function automatic int find_way(int p, int set, logic [TAG_W-1:0] tg);
        for (int w = 0; w < WAYS; w++)
            if (shadow_state[p][set][w] != ST_I && shadow_tag[p][set][w] == tg)
                return w;
        return -1;
    endfunction

    function automatic int count_sharers(int req, int lim, int set, logic [TAG_W-1:0] tg);
        int n;
        n = 0;
        for (int i = 0; i < lim; i++)
            if (i != req && find_way(i, set, tg) >= 0)
                n++;
        return n;
    endfunction

    // Apply one bus operation to every other participating cache.
    function automatic void snoop_bus(proto_t pr, int op, int req, int lim, int set,
                                      logic [TAG_W-1:0] tg, inout int interv,
                                      inout int inval, inout int flush, inout int clean);
        int w;
        lstate_t st;
        for (int i = 0; i < lim; i++) begin
            if (i == req)
                continue;
            w = find_way(i, set, tg);
            if (w < 0)
                continue;
            st = shadow_state[i][set][w];
            if (pr == PROTO_MSI) begin
                if (op == BUS_RD) begin
                    if (st == ST_M) begin st = ST_S; flush++; interv++; end
                end else begin
                    if (st == ST_M) begin st = ST_I; inval++; flush++; end
                    else if (st == ST_S) begin st = ST_I; inval++; end
                end
            end else if (pr == PROTO_MESI) begin
                if (op == BUS_RD) begin
                    if (st == ST_M) begin st = ST_S; flush++; interv++; end
                    else if (st == ST_E) begin st = ST_S; clean++; interv++; end
                    else if (st == ST_S) clean++;
                end else if (op == BUS_RDX) begin
                    if (st == ST_M) begin st = ST_I; flush++; inval++; end
                    else if (st == ST_E || st == ST_S) begin
                        st = ST_I; clean++; inval++;
                    end
                end else begin
                    if (st == ST_S) begin st = ST_I; inval++; end
                end
            end else begin
                if (op == BUS_RD) begin
                    if (st == ST_E) begin st = ST_SC; interv++; end
                    else if (st == ST_M) begin st = ST_SM; flush++; interv++; end
                    else if (st == ST_SM) flush++;
                end else begin
                    if (st == ST_SM) st = ST_SC;
                end
            end
            shadow_state[i][set][w] = st;
        end
    endfunction

    function automatic logic [1:0] clip3(int v);
        return (v > 3) ? 2'd3 : v[1:0];
    endfunction

    // Work out the outcome of one access and update the shadow arrays.
    function automatic result_t predict_access(access_t a);
        result_t r;
        int req, set, lim, way, vic, n, iv, inv, fl, cl;
        logic [TAG_W-1:0] tg;
        logic [STAMP_W-1:0] now, mn;
        logic wr, was_sm;
        lstate_t st;
        r = '0;
        if (cur_proto == PROTO_NONE)
            return r;
        req = a.requester;
        set = a.address[OFS_W +: SET_W];
        tg  = a.address[31 -: TAG_W];
        wr  = a.func;
        lim = (cur_active > NUM_PROCS) ? NUM_PROCS : cur_active;
        iv = 0; inv = 0; fl = 0; cl = 0;
        proc_clock[req] = proc_clock[req] + 1;
        now = proc_clock[req];
        way = find_way(req, set, tg);
        if (way < 0) begin
            vic = WAYS;
            for (int w = 0; w < WAYS; w++)
                if (vic == WAYS && shadow_state[req][set][w] == ST_I)
                    vic = w;
            if (vic == WAYS) begin
                vic = 0;
                mn = shadow_stamp[req][set][0];
                for (int w = 1; w < WAYS; w++)
                    if (shadow_stamp[req][set][w] <= mn) begin
                        vic = w;
                        mn = shadow_stamp[req][set][w];
                    end
            end
            st = shadow_state[req][set][vic];
            r.victim_writeback = (st == ST_M) || (st == ST_SM);
            shadow_tag[req][set][vic] = tg;
            shadow_stamp[req][set][vic] = now;
            shadow_state[req][set][vic] = ST_S;
            if (cur_proto == PROTO_MSI) begin
                if (wr) begin
                    st = ST_M; r.bus_read_exclusive = 1'b1;
                    snoop_bus(cur_proto, BUS_RDX, req, lim, set, tg, iv, inv, fl, cl);
                end else begin
                    st = ST_S; r.bus_read = 1'b1;
                    snoop_bus(cur_proto, BUS_RD, req, lim, set, tg, iv, inv, fl, cl);
                end
            end else if (cur_proto == PROTO_MESI) begin
                n = count_sharers(req, lim, set, tg);
                r.cache_to_cache = (n != 0);
                if (wr) begin
                    st = ST_M; r.bus_read_exclusive = 1'b1;
                    snoop_bus(cur_proto, BUS_RDX, req, lim, set, tg, iv, inv, fl, cl);
                end else begin
                    st = (n != 0) ? ST_S : ST_E; r.bus_read = 1'b1;
                    snoop_bus(cur_proto, BUS_RD, req, lim, set, tg, iv, inv, fl, cl);
                end
            end else begin
                r.bus_read = 1'b1;
                snoop_bus(cur_proto, BUS_RD, req, lim, set, tg, iv, inv, fl, cl);
                if (wr) begin
                    r.bus_update = 1'b1;
                    snoop_bus(cur_proto, BUS_UPD, req, lim, set, tg, iv, inv, fl, cl);
                end
                n = count_sharers(req, lim, set, tg);
                if (wr)
                    st = (n != 0) ? ST_SM : ST_M;
                else
                    st = (n != 0) ? ST_SC : ST_E;
            end
            shadow_state[req][set][vic] = st;
        end else begin
            r.hit = 1'b1;
            st = shadow_state[req][set][way];
            shadow_stamp[req][set][way] = now;
            if (cur_proto == PROTO_MSI) begin
                if (st == ST_S && wr) begin
                    st = ST_M; r.bus_read_exclusive = 1'b1;
                    snoop_bus(cur_proto, BUS_RDX, req, lim, set, tg, iv, inv, fl, cl);
                end
            end else if (cur_proto == PROTO_MESI) begin
                if (st == ST_S) begin
                    if (wr) begin
                        st = ST_M; r.bus_upgrade = 1'b1;
                        snoop_bus(cur_proto, BUS_UPGR, req, lim, set, tg, iv, inv, fl, cl);
                    end
                end else if (st != ST_M && wr) begin
                    st = ST_M;
                end
            end else begin
                if (st == ST_M) begin
                end else if (st == ST_E) begin
                    if (wr) st = ST_M;
                end else if (wr) begin
                    was_sm = (st == ST_SM);
                    r.bus_update = 1'b1;
                    snoop_bus(cur_proto, BUS_UPD, req, lim, set, tg, iv, inv, fl, cl);
                    n = count_sharers(req, lim, set, tg);
                    if (n == 0) st = ST_M;
                    else if (!was_sm) st = ST_SM;
                end
            end
            shadow_state[req][set][way] = st;
        end
        r.final_state = st;
        r.interventions = clip3(iv);
        r.invalidations = clip3(inv);
        r.flushes = clip3(fl);
        r.clean_supplies = clip3(cl);
        return r;
    endfunction

    // Addresses drawn from a few sets and a small tag pool so that lines are
    // shared, hit and evicted; now and then a fully random address.
    function automatic access_t random_access();
        access_t a;
        int k;
        logic [TAG_W-1:0] tg;
        logic [SET_W-1:0] set;
        a.requester = 2'($urandom_range(0, 3));
        a.func = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
            a.address = $urandom;
        end else begin
            k = $urandom_range(0, 11);
            tg = (k == 11) ? {TAG_W{1'b1}} : TAG_W'(k) | (TAG_W'(k & 1) << (TAG_W - 1));
            set = ($urandom_range(0, 7) == 0) ? SET_W'($urandom) : SET_W'($urandom_range(0, 3));
            a.address = {tg, set, OFS_W'($urandom)};
        end
        return a;
    endfunction

    // Input driver: a new transfer is offered only once the last was taken.
    always @(negedge aclk) begin
        if (!s_valid || input_taken) begin
            input_taken = 0;
            if (pending_accesses.size() > 0 && $urandom_range(0, 99) >= src_idle) begin
                s_requester <= pending_accesses[0].requester;
                s_address <= pending_accesses[0].address;
                s_func <= pending_accesses[0].func;
                void'(pending_accesses.pop_front());
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    // Monitor: predict on each input transfer, check each result transfer.
    always @(posedge aclk) begin
        result_t got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("snoopy_coherence_cache_controller_core verification failed");
            $finish;
        end else if (aresetn) begin
            if (s_valid && s_ready) begin
                input_taken = 1;
                expected_results.push_back(predict_access({s_requester, s_address, s_func}));
            end
            if (m_valid && m_ready) begin
                got = {m_hit, m_final_state, m_bus_read, m_bus_read_exclusive,
                       m_bus_upgrade, m_bus_update, m_victim_writeback,
                       m_cache_to_cache, m_interventions, m_invalidations,
                       m_flushes, m_clean_supplies};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transfer: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    task automatic write_reg(logic idx, logic [2:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_PROTOCOL)
            cur_proto = val[1:0];
        else
            cur_active = val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_accesses.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Stimulus sequence.
    initial begin
        for (int p = 0; p < NUM_PROCS; p++) begin
            proc_clock[p] = '0;
            for (int s = 0; s < SETS; s++)
                for (int w = 0; w < WAYS; w++) begin
                    shadow_tag[p][s][w] = '0;
                    shadow_state[p][s][w] = ST_I;
                    shadow_stamp[p][s][w] = '0;
                end
        end
        cur_proto = PROTO_MSI;
        cur_active = 3'd4;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: address extremes, every requester reading the same line, then a
        // write and a read of it, and a full set forced into eviction of dirty lines.
        pending_accesses.push_back('{2'd0, 32'h0000_0000, 1'b0});
        pending_accesses.push_back('{2'd3, 32'hFFFF_FFFF, 1'b1});
        for (int r = 0; r < 4; r++)
            pending_accesses.push_back('{r[1:0], 32'h0000_1040, 1'b0});
        pending_accesses.push_back('{2'd2, 32'h0000_1040, 1'b1});
        pending_accesses.push_back('{2'd1, 32'h0000_1040, 1'b0});
        for (int t = 0; t < 10; t++)
            pending_accesses.push_back('{2'd1, {18'(t), 8'd5, 6'd0}, 1'b1});
        pending_accesses.push_back('{2'd1, 32'h0000_0140, 1'b0});
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_PROTOCOL, {1'b0, PHASE_PROTO[ph]});
            write_reg(CFG_ACTIVE, PHASE_ACTIVE[ph]);
            if (ph < 4) begin
                src_idle = 6; snk_idle = 87;
            end else if (ph < 7) begin
                src_idle = 87; snk_idle = 6;
            end else begin
                src_idle = 0; snk_idle = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_accesses.push_back(random_access());
            drain();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("snoopy_coherence_cache_controller_core verification clean");
        else
            $display("snoopy_coherence_cache_controller_core verification failed");
        $finish;
    end

endmodule
